// ----- hdl/lld_pkg.sv -----
// Shared types and constants for the least-loaded handle dispatcher.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lld_pkg;

	// Sizing
	localparam int NUM_WORKERS      = 8;
	localparam int WORDS_PER_WORKER = 64;
	localparam int BITS_PER_WORD    = 64;
	localparam int BITMAP_BITS      = WORDS_PER_WORKER * BITS_PER_WORD;
	localparam int HANDLE_BASE      = 3;

	// Derived widths
	localparam int WIDX_W  = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
	localparam int ACT_W   = $clog2(NUM_WORKERS + 1);
	localparam int WORD_AW = (WORDS_PER_WORKER > 1) ? $clog2(WORDS_PER_WORKER) : 1;
	localparam int BIT_W   = 6;
	localparam int ROW_W   = NUM_WORKERS * BITS_PER_WORD;

	// Fixed field widths
	localparam int HANDLE_W = 13;
	localparam int WORKER_W = 3;
	localparam int CFG_W    = 4;
	localparam int COUNT_W  = 13;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		OP_ADD_AUTO   = 2'd0,
		OP_ADD_DIRECT = 2'd1,
		OP_LOOKUP     = 2'd2,
		OP_DELETE     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_DUP    = 2'd1,
		ST_ABSENT = 2'd2,
		ST_BAD    = 2'd3
	} status_t;

	// Count update request from the control stage to the count file
	typedef struct packed {
		logic              en;
		logic              inc;
		logic [WIDX_W-1:0] idx;
	} cnt_upd_t;

endpackage

`default_nettype wire

// ----- hdl/lld_bitmap_ram.sv -----
// Membership bitmap memory: one row per bitmap word, all workers side by side.
// Registered read, one write port, row valid bits cleared at reset. Uses lld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lld_bitmap_ram
	import lld_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               rd_en,
	input  wire logic [WORD_AW-1:0] rd_addr,
	output logic      [ROW_W-1:0]   rd_data,
	input  wire logic               wr_en,
	input  wire logic [WORD_AW-1:0] wr_addr,
	input  wire logic [ROW_W-1:0]   wr_data
);

	logic [ROW_W-1:0]            mem [WORDS_PER_WORKER];
	logic [ROW_W-1:0]            rdata_q;
	logic [WORDS_PER_WORKER-1:0] row_valid_q;
	logic                        rvalid_q;

	// Write and read the storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Track written rows; an unwritten row reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- hdl/lld_count_file.sv -----
// Per-worker owned-handle counters and least-loaded worker selection.
// Saturating increment, floored decrement. Uses lld_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lld_count_file
	import lld_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ACT_W-1:0]  active,
	input  wire cnt_upd_t          upd,
	output logic      [WIDX_W-1:0] pick
);

	logic [COUNT_W-1:0] cnt_q [NUM_WORKERS];

	// Apply at most one increment or decrement per completed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORKERS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (upd.en) begin
			if (upd.inc) begin
				if (cnt_q[upd.idx] != COUNT_MAX) begin
					cnt_q[upd.idx] <= cnt_q[upd.idx] + COUNT_W'(1);
				end
			end else if (cnt_q[upd.idx] != '0) begin
				cnt_q[upd.idx] <= cnt_q[upd.idx] - COUNT_W'(1);
			end
		end
	end

	// Scan active workers; smallest count wins, ties go to the higher index
	always_comb begin
		logic [COUNT_W-1:0] best;
		best = cnt_q[0];
		pick = '0;
		for (int i = 1; i < NUM_WORKERS; i++) begin
			if ((32'(i) < 32'(active)) && !(best < cnt_q[i])) begin
				best = cnt_q[i];
				pick = WIDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/least_loaded_fd_dispatcher.sv -----
// Least-loaded handle dispatcher, top level.
// The request is registered while its bitmap row is read; the result beat is
// registered once the check-and-write-back on that row is done and the result
// register is free. No new request is taken until the current one is done.
// Reset: asynchronous; bitmap rows are invalidated at once, counts cleared,
// worker_count returns to 8. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module least_loaded_fd_dispatcher
	import lld_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration: worker_count
	input  wire logic        cfg_we,
	input  wire logic [3:0]  cfg_wdata,
	// Request stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // handle[12:0], target_worker[15:13]
	input  wire logic [1:0]  s_axis_tuser,  // operation[1:0]
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // worker[2:0], zero fill [7:3]
	output logic [1:0]       m_axis_tuser   // status[1:0]
);

	logic [CFG_W-1:0]    cfg_q;
	logic [ACT_W-1:0]    active;

	logic                in_beat;
	op_t                 in_op;
	logic [HANDLE_W-1:0] in_handle;
	logic [HANDLE_W-1:0] in_off;
	logic [WORKER_W-1:0] in_target;
	logic                in_bad;

	logic                busy_q;
	op_t                 op_s1;
	logic                bad_s1;
	logic [WORD_AW-1:0]  word_s1;
	logic [BIT_W-1:0]    bit_s1;
	logic [WORKER_W-1:0] target_s1;
	logic [WIDX_W-1:0]   pick_s1;

	logic [WIDX_W-1:0]   pick;
	logic [ROW_W-1:0]    row;
	logic [ROW_W-1:0]    new_row;
	logic                row_we;
	logic                done;
	logic                found;
	logic [WIDX_W-1:0]   owner;
	logic [WIDX_W-1:0]   dst;
	logic                set_bit;
	logic                clr_bit;
	status_t             res_status;
	logic [WIDX_W-1:0]   res_worker;
	cnt_upd_t            upd;

	logic                out_valid_q;
	status_t             status_q;
	logic [WORKER_W-1:0] worker_q;

	// Hold the worker count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(8);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Clamp the worker count into 1 .. NUM_WORKERS
	always_comb begin
		if (cfg_q == '0) begin
			active = ACT_W'(1);
		end else if (32'(cfg_q) > NUM_WORKERS) begin
			active = ACT_W'(NUM_WORKERS);
		end else begin
			active = ACT_W'(cfg_q);
		end
	end

	// Decode the request beat
	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign in_op     = op_t'(s_axis_tuser);
	assign in_handle = s_axis_tdata[12:0];
	assign in_target = s_axis_tdata[15:13];
	assign in_off    = in_handle - HANDLE_W'(HANDLE_BASE);
	assign in_bad    = (32'(in_handle) < HANDLE_BASE)
		|| (32'(in_off) >= BITMAP_BITS)
		|| ((in_op == OP_ADD_DIRECT) && (32'(in_target) >= 32'(active)));

	assign s_axis_tready = !busy_q;

	// Capture the request while its bitmap row is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_beat) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_s1     <= in_op;
			bad_s1    <= in_bad;
			word_s1   <= WORD_AW'(in_off >> BIT_W);
			bit_s1    <= in_off[BIT_W-1:0];
			target_s1 <= in_target;
			pick_s1   <= pick;
		end
	end

	lld_bitmap_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_beat),
		.rd_addr (WORD_AW'(in_off >> BIT_W)),
		.rd_data (row),
		.wr_en   (row_we),
		.wr_addr (word_s1),
		.wr_data (new_row)
	);

	lld_count_file u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.active (active),
		.upd    (upd),
		.pick   (pick)
	);

	// Finish when the result register is free or being drained
	assign done = busy_q && (!out_valid_q || m_axis_tready);

	// Find the lowest active worker that owns the handle
	always_comb begin
		found = 1'b0;
		owner = '0;
		for (int k = NUM_WORKERS - 1; k >= 0; k--) begin
			if ((32'(k) < 32'(active)) && row[k*BITS_PER_WORD + int'(bit_s1)]) begin
				found = 1'b1;
				owner = WIDX_W'(k);
			end
		end
	end

	// Decide the result and the state update
	always_comb begin
		dst        = (op_s1 == OP_ADD_AUTO) ? pick_s1 : WIDX_W'(target_s1);
		set_bit    = 1'b0;
		clr_bit    = 1'b0;
		res_status = ST_OK;
		res_worker = '0;
		if (bad_s1) begin
			res_status = ST_BAD;
		end else begin
			case (op_s1)
				OP_ADD_AUTO, OP_ADD_DIRECT: begin
					if (found) begin
						res_status = ST_DUP;
						res_worker = owner;
					end else begin
						set_bit    = 1'b1;
						res_worker = dst;
					end
				end
				OP_LOOKUP: begin
					if (found) begin
						res_worker = owner;
					end else begin
						res_status = ST_ABSENT;
					end
				end
				OP_DELETE: begin
					if (found) begin
						clr_bit    = 1'b1;
						res_worker = owner;
					end else begin
						res_status = ST_ABSENT;
					end
				end
				default: begin
					res_status = ST_BAD;
				end
			endcase
		end
	end

	// Modify one bit of the row and write it back
	always_comb begin
		logic [BITS_PER_WORD-1:0] mask;
		mask    = BITS_PER_WORD'(1) << bit_s1;
		new_row = row;
		for (int k = 0; k < NUM_WORKERS; k++) begin
			if (set_bit && (dst == WIDX_W'(k))) begin
				new_row[k*BITS_PER_WORD +: BITS_PER_WORD] =
					row[k*BITS_PER_WORD +: BITS_PER_WORD] | mask;
			end
			if (clr_bit && (owner == WIDX_W'(k))) begin
				new_row[k*BITS_PER_WORD +: BITS_PER_WORD] =
					row[k*BITS_PER_WORD +: BITS_PER_WORD] & ~mask;
			end
		end
	end

	assign row_we  = done && (set_bit || clr_bit);
	assign upd.en  = row_we;
	assign upd.inc = set_bit;
	assign upd.idx = set_bit ? dst : owner;

	// Hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= res_status;
			worker_q <= WORKER_W'(res_worker);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {5'b0, worker_q};

endmodule

`default_nettype wire

// ----- hdl/lld_checker.sv -----
// Port-level checks for the dispatcher, bound to the top level.
// Uses lld_pkg for the status codes.
`timescale 1ns / 1ps
`default_nettype none

module lld_checker
	import lld_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// A pending result beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result beat withdrawn before it was taken");

	// One request at a time: no new beat right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("request taken while another is in flight");

	// With the output free, a request must yield its result beat once its row read and its result are registered
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
		else $error("result missing two cycles after request");

	// Rejected or missing handles report worker zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && ((m_axis_tuser == ST_BAD) || (m_axis_tuser == ST_ABSENT)))
		|-> (m_axis_tdata == 8'd0))
		else $error("nonzero worker on a failed request");

endmodule

bind least_loaded_fd_dispatcher lld_checker u_lld_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
